// ----- hw/rtl/tcw_pkg.sv -----
// types, constants and codes shared by the text console writer
package tcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    localparam int CMD_W      = 2;
    localparam int POS_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ATTR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_CHAR   = 2'd2;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;
    localparam logic [CHAR_W-1:0] ERROR_CHAR_RST   = 8'd69;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              use_cursor;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic [CHAR_W-1:0] character;
        logic [ATTR_W-1:0] attribute;
    } t_req;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_column;
        logic [POS_W-1:0]  cursor_row;
        logic              out_of_range;
        logic              scrolled;
        logic [CHAR_W-1:0] cell_character;
        logic [ATTR_W-1:0] cell_attribute;
    } t_rsp;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_SCROLL,
        SW_CLEAR
    } t_sweep_kind;

    typedef struct packed {
        logic        start;
        t_sweep_kind kind;
    } t_sweep_cmd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

endpackage

// ----- hw/rtl/tcw_req_if.sv -----
// request channel of the text console writer
interface tcw_req_if;
    import tcw_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/tcw_rsp_if.sv -----
// response channel of the text console writer
interface tcw_rsp_if;
    import tcw_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/text_console_writer.sv -----
// text console writer: top level with command sequencer and cursor
//
// A text-mode console buffer of ROWS x COLS cells (25 x 80 by default), each cell
// holding a character byte and an attribute byte, plus one cursor. After reset the
// block runs a zeroing pass over the buffer, one cell per cycle, and takes no
// request until it is done; configuration writes are taken at any time. A
// put-character or read-cell transaction makes its single buffer access (a write,
// or a read into the ram's output register) at accept; the S_RESP state then loads
// the response register once the response slot is free. A put that moves the
// cursor off the bottom row, and every clear, stream through the whole buffer one
// cell a cycle in the sweep engine. The response register decouples the two sides:
// a new request is taken while the previous response still waits for its sink.
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tcw_req_if.sink                       i_req,
    tcw_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_SWEEP,
        S_RESP
    } t_state;

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_cur_col, n_cur_col;
    logic [POS_W-1:0]  r_cur_row, n_cur_row;
    logic              r_res_oor, n_res_oor;
    logic              r_res_scr, n_res_scr;
    logic              r_res_rd, n_res_rd;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out, n_out;

    // configuration registers
    logic [ATTR_W-1:0] r_def_attr;
    logic [ATTR_W-1:0] r_err_attr;
    logic [CHAR_W-1:0] r_err_char;

    // request decode
    t_req              req;
    logic              accept;
    logic              coord_bad;
    logic              bad;
    logic [POS_W-1:0]  sel_col;
    logic [POS_W-1:0]  sel_row;
    logic [ADDR_W-1:0] pos;
    logic              last_col;
    logic              last_row;
    logic              adv_wrap;
    logic [ATTR_W-1:0] put_attr;

    // buffer access
    t_mem_wr           top_wr, sw_wr, mem_wr;
    t_mem_rd           top_rd, sw_rd, mem_rd;
    logic [CELL_W-1:0] rdata;
    t_sweep_cmd        sw_cmd;
    logic              sw_busy;
    logic              sw_done;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign req         = i_req.data;

    always_comb begin
        coord_bad = (req.column >= POS_W'(COLS)) || (req.row >= POS_W'(ROWS));
        bad       = !req.use_cursor && coord_bad;
        sel_col   = req.use_cursor ? r_cur_col : req.column;
        sel_row   = req.use_cursor ? r_cur_row : req.row;
        // row * COLS is a constant multiply on a narrow operand
        pos       = ADDR_W'(sel_row) * ADDR_W'(COLS) + ADDR_W'(sel_col);
        last_col  = (sel_col == POS_W'(COLS - 1));
        last_row  = (sel_row == POS_W'(ROWS - 1));
        // newline, or a write into the last column, moves to the next row start
        adv_wrap  = (req.character == NEWLINE_CODE) || last_col;
        put_attr  = (req.attribute == '0) ? r_def_attr : req.attribute;
    end

    always_comb begin
        n_state     = r_state;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_res_oor   = r_res_oor;
        n_res_scr   = r_res_scr;
        n_res_rd    = r_res_rd;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        top_wr.en   = 1'b0;
        top_wr.addr = pos;
        top_wr.data = {put_attr, req.character};
        top_rd.en   = 1'b0;
        top_rd.addr = pos;
        sw_cmd.start = 1'b0;
        sw_cmd.kind  = SW_SCROLL;

        // response slot drains whenever the sink takes it
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // power-up zeroing pass
                if (sw_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_res_oor = 1'b0;
                    n_res_scr = 1'b0;
                    n_res_rd  = 1'b0;
                    n_state   = S_RESP;
                    unique case (req.command)
                        CMD_PUT: begin
                            if (bad) begin
                                // error mark at the last cell, cursor stays
                                top_wr.en   = 1'b1;
                                top_wr.addr = ADDR_W'(CELLS - 1);
                                top_wr.data = {r_err_attr, r_err_char};
                                n_res_oor   = 1'b1;
                            end else begin
                                top_wr.en = (req.character != NEWLINE_CODE);
                                if (!adv_wrap) begin
                                    n_cur_col = sel_col + POS_W'(1);
                                    n_cur_row = sel_row;
                                end else if (!last_row) begin
                                    n_cur_col = '0;
                                    n_cur_row = sel_row + POS_W'(1);
                                end else begin
                                    // ran off the bottom: scroll, stay on bottom row
                                    n_cur_col    = '0;
                                    n_cur_row    = POS_W'(ROWS - 1);
                                    n_res_scr    = 1'b1;
                                    sw_cmd.start = 1'b1;
                                    sw_cmd.kind  = SW_SCROLL;
                                    n_state      = S_SWEEP;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            // spaces everywhere, then the final scroll zeroes
                            // the bottom row; the sweep does both in one pass
                            n_cur_col    = '0;
                            n_cur_row    = '0;
                            n_res_scr    = 1'b1;
                            sw_cmd.start = 1'b1;
                            sw_cmd.kind  = SW_CLEAR;
                            n_state      = S_SWEEP;
                        end
                        CMD_READ: begin
                            if (bad) begin
                                n_res_oor = 1'b1;
                            end else begin
                                top_rd.en = 1'b1;
                                n_res_rd  = 1'b1;
                            end
                        end
                        default: begin
                            // unused code: no effect
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (sw_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                // read data stays on the ram output, nothing reads meanwhile
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.cursor_column  = r_cur_col;
                    n_out.cursor_row     = r_cur_row;
                    n_out.out_of_range   = r_res_oor;
                    n_out.scrolled       = r_res_scr;
                    n_out.cell_character = r_res_rd ? rdata[CHAR_W-1:0] : '0;
                    n_out.cell_attribute = r_res_rd ? rdata[CELL_W-1:CHAR_W] : '0;
                    n_state              = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_out_valid <= n_out_valid;
        end
        r_res_oor <= n_res_oor;
        r_res_scr <= n_res_scr;
        r_res_rd  <= n_res_rd;
        r_out     <= n_out;
    end

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= DEFAULT_ATTR_RST;
            r_err_attr <= ERROR_ATTR_RST;
            r_err_char <= ERROR_CHAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEFAULT_ATTR: r_def_attr <= i_cfg_wdata;
                CFG_ERROR_ATTR:   r_err_attr <= i_cfg_wdata;
                CFG_ERROR_CHAR:   r_err_char <= i_cfg_wdata;
                default: begin
                    // index beyond the register list is dropped
                end
            endcase
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // sweep engine owns the buffer while it runs
    assign mem_wr = sw_busy ? sw_wr : top_wr;
    assign mem_rd = sw_busy ? sw_rd : top_rd;

    tcw_sweep u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (sw_cmd),
        .i_fill_attr (r_def_attr),
        .i_rdata     (rdata),
        .o_rd        (sw_rd),
        .o_wr        (sw_wr),
        .o_busy      (sw_busy),
        .o_done      (sw_done)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_wr.en),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_re    (mem_rd.en),
        .i_raddr (mem_rd.addr),
        .o_rdata (rdata)
    );
endmodule

// ----- hw/rtl/tcw_ram.sv -----
// generic simple dual-port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/tcw_sweep.sv -----
// whole-buffer sweep engine: power-up zeroing, scroll-up and clear
module tcw_sweep (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tcw_pkg::t_sweep_cmd       i_cmd,
    input  logic [tcw_pkg::ATTR_W-1:0] i_fill_attr,
    input  logic [tcw_pkg::CELL_W-1:0] i_rdata,
    output tcw_pkg::t_mem_rd          o_rd,
    output tcw_pkg::t_mem_wr          o_wr,
    output logic                      o_busy,
    output logic                      o_done
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        WS_ZERO,
        WS_SPACE,
        WS_MOVE
    } t_wsel;

    logic              r_busy, n_busy;
    t_sweep_kind       r_kind, n_kind;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_wp_vld, n_wp_vld;
    logic [ADDR_W-1:0] r_wp_addr, n_wp_addr;
    t_wsel             r_wp_sel, n_wp_sel;
    logic              issue;
    logic              upper;
    logic [CNT_W-1:0]  rd_sum;

    always_comb begin
        issue  = r_busy && (r_cnt < CNT_W'(CELLS));
        upper  = r_cnt < CNT_W'(CELLS - COLS);
        rd_sum = r_cnt + CNT_W'(COLS);

        n_busy    = r_busy;
        n_kind    = r_kind;
        n_cnt     = r_cnt;
        n_wp_vld  = 1'b0;
        n_wp_addr = r_cnt[ADDR_W-1:0];
        n_wp_sel  = WS_ZERO;

        o_rd.en   = 1'b0;
        o_rd.addr = rd_sum[ADDR_W-1:0];
        o_done    = r_busy && !issue;

        // each cell: read the row below (scroll only), write it in the next cycle
        if (issue) begin
            n_wp_vld = 1'b1;
            n_cnt    = r_cnt + CNT_W'(1);
            unique case (r_kind)
                SW_SCROLL: begin
                    if (upper) begin
                        n_wp_sel = WS_MOVE;
                        o_rd.en  = 1'b1;
                    end
                end
                SW_CLEAR: begin
                    if (upper) begin
                        n_wp_sel = WS_SPACE;
                    end
                end
                SW_INIT: begin
                    n_wp_sel = WS_ZERO;
                end
            endcase
        end else if (r_busy) begin
            n_busy = 1'b0;
        end

        if (i_cmd.start && !r_busy) begin
            n_busy = 1'b1;
            n_kind = i_cmd.kind;
            n_cnt  = '0;
        end

        o_wr.en   = r_wp_vld;
        o_wr.addr = r_wp_addr;
        unique case (r_wp_sel)
            WS_MOVE:  o_wr.data = i_rdata;
            WS_SPACE: o_wr.data = {i_fill_attr, SPACE_CODE};
            WS_ZERO:  o_wr.data = '0;
            default:  o_wr.data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_kind   <= SW_INIT;
            r_cnt    <= '0;
            r_wp_vld <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_kind   <= n_kind;
            r_cnt    <= n_cnt;
            r_wp_vld <= n_wp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wp_addr <= n_wp_addr;
        r_wp_sel  <= n_wp_sel;
    end

    assign o_busy = r_busy;
endmodule

// ----- hw/rtl/tcw_chk.sv -----
// port-level checker for the text console writer and its bind
module tcw_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input tcw_pkg::t_rsp i_rsp_data
);
    import tcw_pkg::*;

    // one transaction at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken back to back");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.cursor_column < POS_W'(COLS)) &&
                        (i_rsp_data.cursor_row < POS_W'(ROWS)))
        else $error("cursor outside the screen");

    a_bad_no_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_data.out_of_range && i_rsp_data.scrolled))
        else $error("bad position reported together with scroll");

    // scroll leaves cursor on the bottom row start, clear at home
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.scrolled |->
            (i_rsp_data.cursor_column == '0) &&
            ((i_rsp_data.cursor_row == POS_W'(ROWS - 1)) ||
             (i_rsp_data.cursor_row == '0)))
        else $error("cursor not at a row start after scroll");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");
endmodule

bind text_console_writer tcw_chk u_tcw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ----- tb/tb.sv -----
// testbench for the text console writer: directed script, random traffic, scoreboard
`timescale 1ns / 100ps

module tb;
    import tcw_pkg::*;

    // generous ceiling: every transaction a full buffer sweep plus worst stalls, several times
    localparam int unsigned RUN_LIMIT    = 4_000_000;
    localparam int unsigned PHASE_ITEMS  = 110;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MAX_GAP      = 14;
    localparam int unsigned SETTLE       = 16;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam t_rsp        NO_RSP       = '0;
    // command code with no meaning, must be ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one row of the directed script: request, and a typed-in result where obvious
    typedef struct packed {
        t_req req;
        logic known;
        t_rsp rsp;
    } t_script_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tcw_req_if req_if ();
    tcw_rsp_if rsp_if ();

    text_console_writer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // shadow of the console: cell buffer, cursor and the three registers
    logic [CELL_W-1:0] screen_model [CELLS];
    int unsigned       cursor_pos;
    logic [ATTR_W-1:0] dflt_attr;
    logic [ATTR_W-1:0] err_attr;
    logic [CHAR_W-1:0] err_char;

    // results owed by the block, oldest first
    t_rsp awaited_responses [$];
    t_script_row script_rows [$];

    int unsigned fail_count = 0;
    int unsigned rx_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog: a hung block ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    function automatic t_req req_of(input logic [CMD_W-1:0] cmd, input bit uc,
                                    input int col, input int row_n,
                                    input int ch, input int at);
        t_req r;
        r.command    = cmd;
        r.use_cursor = uc;
        r.column     = POS_W'(col);
        r.row        = POS_W'(row_n);
        r.character  = CHAR_W'(ch);
        r.attribute  = ATTR_W'(at);
        return r;
    endfunction

    function automatic t_rsp rsp_of(input int ccol, input int crow, input bit oor,
                                    input bit scr, input int ch, input int at);
        t_rsp o;
        o.cursor_column  = POS_W'(ccol);
        o.cursor_row     = POS_W'(crow);
        o.out_of_range   = oor;
        o.scrolled       = scr;
        o.cell_character = CHAR_W'(ch);
        o.cell_attribute = ATTR_W'(at);
        return o;
    endfunction

    // apply one request to the shadow console and return the result it must produce
    function automatic t_rsp console_apply(input t_req r);
        t_rsp        o;
        int unsigned pos;
        bit          bad;
        bit          rolled;
        logic [ATTR_W-1:0] at;
        o      = '0;
        pos    = 0;
        bad    = 1'b0;
        rolled = 1'b0;

        // explicit position only matters when the cursor is not selected
        if (r.use_cursor)
            pos = cursor_pos;
        else if (int'(r.column) >= COLS || int'(r.row) >= ROWS)
            bad = 1'b1;
        else
            pos = int'(r.row) * COLS + int'(r.column);

        case (r.command)
            CMD_PUT: begin
                if (bad) begin
                    // error mark lands on the last cell, cursor stays
                    screen_model[CELLS-1] = {err_attr, err_char};
                end else begin
                    at = (r.attribute == '0) ? dflt_attr : r.attribute;
                    if (r.character == NEWLINE_CODE) begin
                        pos = (pos / COLS + 1) * COLS;
                    end else begin
                        screen_model[pos] = {at, r.character};
                        pos++;
                    end
                    // ran off the end: shift rows up, blank the bottom row
                    if (pos >= CELLS) begin
                        for (int i = 0; i < CELLS - COLS; i++)
                            screen_model[i] = screen_model[i + COLS];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            screen_model[i] = '0;
                        pos    = pos - COLS;
                        rolled = 1'b1;
                    end
                    cursor_pos = pos;
                end
            end
            CMD_CLEAR: begin
                // the last space overruns and scrolls: bottom row ends zeroed
                bad = 1'b0;
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = (i < CELLS - COLS) ? {dflt_attr, SPACE_CODE} : '0;
                rolled     = 1'b1;
                cursor_pos = 0;
            end
            CMD_READ: begin
                if (!bad) begin
                    o.cell_character = screen_model[pos][CHAR_W-1:0];
                    o.cell_attribute = screen_model[pos][CELL_W-1:CHAR_W];
                end
            end
            default: begin
                // unused code: no effect at all
                bad = 1'b0;
            end
        endcase

        o.cursor_column = POS_W'(cursor_pos % COLS);
        o.cursor_row    = POS_W'(cursor_pos / COLS);
        o.out_of_range  = bad;
        o.scrolled      = rolled;
        return o;
    endfunction

    // offer one request after a random gap; valid is only lowered when a gap follows
    task automatic send_request(input t_req r, input bit known = 1'b0,
                                input t_rsp typed = '0);
        int unsigned gap;
        t_rsp        predicted;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!req_if.ready);
        // transaction accepted at this edge
        predicted = console_apply(r);
        awaited_responses.push_back(known ? typed : predicted);
    endtask

    // registers change only while nothing is in flight
    task automatic program_config(input logic [CFG_DATA_W-1:0] dflt,
                                  input logic [CFG_DATA_W-1:0] eattr,
                                  input logic [CFG_DATA_W-1:0] echar);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_DEFAULT_ATTR;
        cfg_wdata <= dflt;
        @(posedge clk);
        cfg_idx   <= CFG_ERROR_ATTR;
        cfg_wdata <= eattr;
        @(posedge clk);
        cfg_idx   <= CFG_ERROR_CHAR;
        cfg_wdata <= echar;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dflt_attr = dflt;
        err_attr  = eattr;
        err_char  = echar;
    endtask

    task automatic drain_responses();
        while (awaited_responses.size() != 0) @(posedge clk);
    endtask

    // random traffic: mostly lines of text that walk the cursor into wrap and scroll,
    // the rest reads, bad positions, raw noise and the odd clear
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned run_len;
        int unsigned col_n;
        int unsigned row_n;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // place the cursor, often near the end of the bottom row
                row_n = ($urandom_range(0, 1) != 0) ? ROWS - 1 : $urandom_range(0, ROWS - 1);
                col_n = ($urandom_range(0, 1) != 0) ? $urandom_range(COLS - 10, COLS - 1)
                                                    : $urandom_range(0, COLS - 1);
                send_request(req_of(CMD_PUT, 1'b0, col_n, row_n, $urandom_range(0, 255),
                                    ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255)));
                run_len = $urandom_range(2, 8);
                // cursor-driven text, with newlines mixed in
                repeat (run_len)
                    send_request(req_of(CMD_PUT, 1'b1, $urandom_range(0, 255),
                                        $urandom_range(0, 255),
                                        ($urandom_range(0, 7) == 0) ? int'(NEWLINE_CODE)
                                                                    : $urandom_range(0, 255),
                                        ($urandom_range(0, 3) == 0) ? 0
                                                                    : $urandom_range(0, 255)));
                // read back where the line started, or at the cursor
                send_request(req_of(CMD_READ, 1'($urandom_range(0, 1)), col_n, row_n, 0, 0));
                sent += run_len + 2;
            end else if (pick < 75) begin
                send_request(req_of(CMD_READ, $urandom_range(0, 2) == 0,
                                    $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                                    $urandom_range(0, 255), $urandom_range(0, 255)));
                sent++;
            end else if (pick < 85) begin
                // bad position for put or read, on either coordinate
                if ($urandom_range(0, 1) != 0)
                    send_request(req_of(($urandom_range(0, 1) != 0) ? CMD_PUT : CMD_READ, 1'b0,
                                        $urandom_range(COLS, 255), $urandom_range(0, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255)));
                else
                    send_request(req_of(($urandom_range(0, 1) != 0) ? CMD_PUT : CMD_READ, 1'b0,
                                        $urandom_range(0, COLS - 1), $urandom_range(ROWS, 255),
                                        $urandom_range(0, 255), $urandom_range(0, 255)));
                sent++;
            end else if (pick < 97) begin
                // raw fields, unused command code included
                send_request(req_of(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 255)));
                sent++;
            end else begin
                send_request(req_of(CMD_CLEAR, 1'($urandom_range(0, 1)), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 255),
                                    $urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    // response side: random stalls, one long hold-off so the block backs up,
    // and each transaction checked against the oldest expectation
    initial begin : response_sink
        int unsigned stall;
        t_rsp        want;
        t_rsp        got;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_count == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
            got = rsp_if.data;
            rx_count++;
            if (awaited_responses.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("response %0d arrived with nothing outstanding", rx_count);
            end else begin
                want = awaited_responses.pop_front();
                if (got.cursor_column !== want.cursor_column ||
                    got.cursor_row !== want.cursor_row ||
                    got.out_of_range !== want.out_of_range ||
                    got.scrolled !== want.scrolled ||
                    got.cell_character !== want.cell_character ||
                    got.cell_attribute !== want.cell_attribute) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"response %0d: expected col %0d row %0d oor %0b scr %0b ",
                                  "ch %0d attr %0d, got col %0d row %0d oor %0b scr %0b ",
                                  "ch %0d attr %0d"}, rx_count,
                                 want.cursor_column, want.cursor_row, want.out_of_range,
                                 want.scrolled, want.cell_character, want.cell_attribute,
                                 got.cursor_column, got.cursor_row, got.out_of_range,
                                 got.scrolled, got.cell_character, got.cell_attribute);
                end
            end
        end
    end

    initial begin : stimulus
        // everything known from time zero
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_DEFAULT_ATTR;
        cfg_wdata    = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        no_idle      = 1'b0;
        cursor_pos   = 0;
        dflt_attr    = DEFAULT_ATTR_RST;
        err_attr     = ERROR_ATTR_RST;
        err_char     = ERROR_CHAR_RST;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = '0;

        // directed script, run with the reset register values
        // fresh buffer reads back zero
        script_rows.push_back({req_of(CMD_READ, 1'b0, 0, 0, 0, 0), 1'b1,
                               rsp_of(0, 0, 1'b0, 1'b0, 0, 0)});
        // zero attribute picks up the default
        script_rows.push_back({req_of(CMD_PUT, 1'b0, 0, 0, 65, 0), 1'b1,
                               rsp_of(1, 0, 1'b0, 1'b0, 0, 0)});
        script_rows.push_back({req_of(CMD_READ, 1'b0, 0, 0, 0, 0), 1'b1,
                               rsp_of(1, 0, 1'b0, 1'b0, 65, 15)});
        // last cell: wraps and scrolls, cursor parks at the bottom row start
        script_rows.push_back({req_of(CMD_PUT, 1'b0, COLS - 1, ROWS - 1, 255, 255), 1'b1,
                               rsp_of(0, ROWS - 1, 1'b0, 1'b1, 0, 0)});
        script_rows.push_back({req_of(CMD_READ, 1'b0, COLS - 1, ROWS - 2, 0, 0), 1'b0, NO_RSP});
        // bad column, bad row, both at the top of their range
        script_rows.push_back({req_of(CMD_PUT, 1'b0, COLS, 0, 7, 9), 1'b1,
                               rsp_of(0, ROWS - 1, 1'b1, 1'b0, 0, 0)});
        script_rows.push_back({req_of(CMD_READ, 1'b0, COLS - 1, ROWS - 1, 0, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_PUT, 1'b0, 0, ROWS, 1, 1), 1'b1,
                               rsp_of(0, ROWS - 1, 1'b1, 1'b0, 0, 0)});
        script_rows.push_back({req_of(CMD_PUT, 1'b0, 255, 255, 255, 255), 1'b1,
                               rsp_of(0, ROWS - 1, 1'b1, 1'b0, 0, 0)});
        script_rows.push_back({req_of(CMD_READ, 1'b0, 255, 255, 0, 0), 1'b1,
                               rsp_of(0, ROWS - 1, 1'b1, 1'b0, 0, 0)});
        // newline on the bottom row scrolls
        script_rows.push_back({req_of(CMD_PUT, 1'b1, 0, 0, NEWLINE_CODE, 0), 1'b0, NO_RSP});
        // newline mid-screen writes nothing, moves to the next row start
        script_rows.push_back({req_of(CMD_PUT, 1'b0, 5, 3, NEWLINE_CODE, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_PUT, 1'b1, 0, 0, 0, 1), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_READ, 1'b1, 0, 0, 0, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_READ, 1'b0, 0, 4, 0, 0), 1'b0, NO_RSP});
        // clear ignores a bad position, always scrolls, homes the cursor
        script_rows.push_back({req_of(CMD_CLEAR, 1'b0, 200, 200, 0, 0), 1'b1,
                               rsp_of(0, 0, 1'b0, 1'b1, 0, 0)});
        script_rows.push_back({req_of(CMD_READ, 1'b0, 0, ROWS - 1, 0, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_READ, 1'b0, COLS - 1, ROWS - 2, 0, 0), 1'b0, NO_RSP});
        // unused command code does nothing, even with a bad position
        script_rows.push_back({req_of(CMD_UNUSED, 1'b0, 255, 255, 255, 255), 1'b1,
                               rsp_of(0, 0, 1'b0, 1'b0, 0, 0)});
        // cursor put ignores the given column and row
        script_rows.push_back({req_of(CMD_PUT, 1'b1, 255, 255, 120, 128), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_PUT, 1'b0, 0, ROWS - 1, NEWLINE_CODE, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_READ, 1'b1, 255, 255, 0, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_PUT, 1'b0, COLS - 1, ROWS - 1, 85, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_UNUSED, 1'b1, 0, 0, 0, 0), 1'b0, NO_RSP});
        script_rows.push_back({req_of(CMD_READ, 1'b0, COLS - 1, 0, 0, 0), 1'b0, NO_RSP});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // the block sits in its zeroing pass until ready rises
        foreach (script_rows[i])
            send_request(script_rows[i].req, script_rows[i].known, script_rows[i].rsp);
        req_if.valid <= 1'b0;
        drain_responses();

        // random phases, each under its own register setting
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: program_config(8'h00, 8'h00, 8'h00);
                1: program_config(8'hFF, 8'hFF, 8'hFF);
                default: program_config(CFG_DATA_W'($urandom_range(0, 255)),
                                        CFG_DATA_W'($urandom_range(0, 255)),
                                        CFG_DATA_W'($urandom_range(0, 255)));
            endcase
            // one phase runs back to back on both sides
            no_idle = (phase == 1);
            run_random_phase(PHASE_ITEMS);
            req_if.valid <= 1'b0;
            drain_responses();
        end

        // let any stray transaction show up before the verdict
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && awaited_responses.size() == 0)
            $display("PASS text_console_writer");
        else
            $display("FAIL text_console_writer");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_req_if.sv
hw/rtl/tcw_rsp_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_sweep.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_chk.sv
tb/tb.sv
